/* hw/rtl/rsps_pkg.sv */
`timescale 1ns / 1ps

package rsps_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int SUM_BITS_DEF   = 32;

  localparam int COUNT_BITS     = 8;
  localparam int STEP_BITS      = 8;
  localparam int KP_BITS        = 16;
  localparam int KI_BITS        = 24;
  localparam int DRIVE_BITS     = 8;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_MIN_BITS   = KI_BITS;

  localparam int GAIN_FRAC_BITS = 24;
  localparam int KP_FRAC_BITS   = 8;
  localparam int KP_SHIFT       = GAIN_FRAC_BITS - KP_FRAC_BITS;
  localparam int KI_SPLIT       = 12;

  localparam int DRIVE_MAX = 100;
  localparam int DRIVE_MIN = -100;

  localparam logic [COUNT_BITS-1:0] TICK_MAX = '1;

  localparam logic [KP_BITS-1:0] KP_RESET = 16'd474;

  localparam logic [CFG_INDEX_BITS-1:0] REG_DIRECTION    = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TARGET_ANGLE = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COUNT_LIMIT  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STEP_SIZE    = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_KP_GAIN      = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_KI_GAIN      = 3'd5;

  typedef struct packed {
    logic                  direction;
    logic [COUNT_BITS-1:0] count_limit;
    logic [STEP_BITS-1:0]  step_size;
  } ramp_cfg_t;

  typedef struct packed {
    logic [KP_BITS-1:0] kp_gain;
    logic [KI_BITS-1:0] ki_gain;
  } gain_cfg_t;

endpackage

/* hw/rtl/rsps_in_if.sv */
`timescale 1ns / 1ps

interface rsps_in_if #(
  parameter int ANGLE_BITS = rsps_pkg::ANGLE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [ANGLE_BITS-1:0] measured_angle;
  logic                         restart;

  modport source (output valid, output measured_angle, output restart, input ready);
  modport sink   (input valid, input measured_angle, input restart, output ready);
endinterface

/* hw/rtl/rsps_out_if.sv */
`timescale 1ns / 1ps

interface rsps_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [rsps_pkg::DRIVE_BITS-1:0] drive;

  modport source (output valid, output drive, input ready);
  modport sink   (input valid, input drive, output ready);
endinterface

/* hw/rtl/rsps_state.sv */
`timescale 1ns / 1ps

module rsps_state #(
  parameter int ANGLE_BITS = rsps_pkg::ANGLE_BITS_DEF,
  parameter int SUM_BITS   = rsps_pkg::SUM_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         up_valid,
  output logic                         up_ready,
  input  logic signed [ANGLE_BITS-1:0] measured_angle,
  input  logic                         restart,
  input  rsps_pkg::ramp_cfg_t          ramp_cfg,
  input  logic signed [ANGLE_BITS-1:0] target_angle,
  output logic                         dn_valid,
  input  logic                         dn_ready,
  output logic signed [ANGLE_BITS+1:0] held_error,
  output logic signed [SUM_BITS-1:0]   error_sum
);
  import rsps_pkg::*;

  localparam int A  = ANGLE_BITS;
  localparam int S  = SUM_BITS;
  localparam int SW = ((S > A + 2) ? S : A + 2) + 1;

  logic                  v_r, v_nxt;
  logic signed [A:0]     ramp_r, ramp_nxt;
  logic [COUNT_BITS-1:0] tick_r, tick_nxt;
  logic signed [A+1:0]   held_r, held_nxt;
  logic signed [S-1:0]   sum_r, sum_nxt;

  logic                  fire;
  logic signed [A:0]     rp0;
  logic signed [A:0]     tgt_x;
  logic [COUNT_BITS-1:0] tick_inc;
  logic                  ramping;
  logic signed [A+1:0]   rp_ext;
  logic signed [A+1:0]   meas_ext;
  logic signed [A+1:0]   step_x;
  logic signed [A+1:0]   moved;
  logic signed [A:0]     moved_sat;
  logic signed [SW-1:0]  sum_w;

  assign up_ready   = !v_r || dn_ready;
  assign fire       = up_valid && up_ready;
  assign dn_valid   = v_r;
  assign held_error = held_r;
  assign error_sum  = sum_r;

  always_comb begin
    rp0      = restart ? {measured_angle[A-1], measured_angle} : ramp_r;
    tgt_x    = {target_angle[A-1], target_angle};
    tick_inc = (tick_r == TICK_MAX) ? tick_r : tick_r + 1'b1;
    ramping  = ramp_cfg.direction ? (rp0 >= tgt_x) : (rp0 <= tgt_x);
    rp_ext   = {rp0[A], rp0};
    meas_ext = {{2{measured_angle[A-1]}}, measured_angle};
    step_x   = $signed({{(A + 2 - STEP_BITS){1'b0}}, ramp_cfg.step_size});
    moved    = ramp_cfg.direction ? (rp_ext - step_x) : (rp_ext + step_x);
    if (moved[A+1] != moved[A]) begin
      moved_sat = moved[A+1] ? {1'b1, {A{1'b0}}} : {1'b0, {A{1'b1}}};
    end else begin
      moved_sat = moved[A:0];
    end

    ramp_nxt = ramp_r;
    tick_nxt = tick_r;
    held_nxt = held_r;
    if (ramping) begin
      held_nxt = rp_ext - meas_ext;
      if (tick_inc >= ramp_cfg.count_limit) begin
        ramp_nxt = moved_sat;
        tick_nxt = '0;
      end else begin
        ramp_nxt = rp0;
        tick_nxt = tick_inc;
      end
    end else begin
      ramp_nxt = tgt_x;
      tick_nxt = tick_inc;
    end

    sum_w = SW'(sum_r) + SW'(held_nxt);
    if ((sum_w[SW-1:S-1] == '0) || (sum_w[SW-1:S-1] == '1)) begin
      sum_nxt = sum_w[S-1:0];
    end else begin
      sum_nxt = sum_w[SW-1] ? {1'b1, {(S-1){1'b0}}} : {1'b0, {(S-1){1'b1}}};
    end

    v_nxt = fire || (v_r && !dn_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r    <= 1'b0;
      ramp_r <= '0;
      tick_r <= '0;
      held_r <= '0;
      sum_r  <= '0;
    end else begin
      v_r <= v_nxt;
      if (fire) begin
        ramp_r <= ramp_nxt;
        tick_r <= tick_nxt;
        held_r <= held_nxt;
        sum_r  <= sum_nxt;
      end
    end
  end

endmodule

/* hw/rtl/rsps_mult.sv */
`timescale 1ns / 1ps

module rsps_mult #(
  parameter int ANGLE_BITS = rsps_pkg::ANGLE_BITS_DEF,
  parameter int SUM_BITS   = rsps_pkg::SUM_BITS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       up_valid,
  output logic                                       up_ready,
  input  logic signed [ANGLE_BITS+1:0]               held_error,
  input  logic signed [SUM_BITS-1:0]                 error_sum,
  input  rsps_pkg::gain_cfg_t                        gain_cfg,
  output logic                                       dn_valid,
  input  logic                                       dn_ready,
  output logic signed [ANGLE_BITS+rsps_pkg::KP_BITS+2:0] prod_p,
  output logic signed [SUM_BITS+rsps_pkg::KI_SPLIT:0]    prod_hi,
  output logic signed [SUM_BITS+rsps_pkg::KI_SPLIT:0]    prod_lo
);
  import rsps_pkg::*;

  localparam int PXW = ANGLE_BITS + KP_BITS + 3;
  localparam int PHW = SUM_BITS + KI_SPLIT + 1;

  logic                  v_r, v_nxt;
  logic signed [PXW-1:0] px_r, px_nxt;
  logic signed [PHW-1:0] ph_r, ph_nxt;
  logic signed [PHW-1:0] pl_r, pl_nxt;
  logic                  fire;

  assign up_ready = !v_r || dn_ready;
  assign fire     = up_valid && up_ready;
  assign dn_valid = v_r;
  assign prod_p   = px_r;
  assign prod_hi  = ph_r;
  assign prod_lo  = pl_r;

  always_comb begin
    px_nxt = $signed({1'b0, gain_cfg.kp_gain}) * held_error;
    ph_nxt = $signed({1'b0, gain_cfg.ki_gain[KI_BITS-1:KI_SPLIT]}) * error_sum;
    pl_nxt = $signed({1'b0, gain_cfg.ki_gain[KI_SPLIT-1:0]}) * error_sum;
    v_nxt  = fire || (v_r && !dn_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      px_r <= px_nxt;
      ph_r <= ph_nxt;
      pl_r <= pl_nxt;
    end
  end

endmodule

/* hw/rtl/rsps_drive.sv */
`timescale 1ns / 1ps

module rsps_drive #(
  parameter int ANGLE_BITS = rsps_pkg::ANGLE_BITS_DEF,
  parameter int SUM_BITS   = rsps_pkg::SUM_BITS_DEF
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           up_valid,
  output logic                                           up_ready,
  input  logic signed [ANGLE_BITS+rsps_pkg::KP_BITS+2:0] prod_p,
  input  logic signed [SUM_BITS+rsps_pkg::KI_SPLIT:0]    prod_hi,
  input  logic signed [SUM_BITS+rsps_pkg::KI_SPLIT:0]    prod_lo,
  rsps_out_if.source                                     out_ch
);
  import rsps_pkg::*;

  localparam int PXW = ANGLE_BITS + KP_BITS + 3;
  localparam int PHW = SUM_BITS + KI_SPLIT + 1;
  localparam int VW  = ((PXW + KP_SHIFT > PHW + KI_SPLIT) ?
                        PXW + KP_SHIFT : PHW + KI_SPLIT) + 2;
  localparam int QW  = VW - GAIN_FRAC_BITS;

  localparam logic signed [QW-1:0]         QMAX = QW'(DRIVE_MAX);
  localparam logic signed [QW-1:0]         QMIN = QW'(DRIVE_MIN);
  localparam logic signed [DRIVE_BITS-1:0] DMAX = DRIVE_BITS'(DRIVE_MAX);
  localparam logic signed [DRIVE_BITS-1:0] DMIN = DRIVE_BITS'(DRIVE_MIN);

  logic                         v_r, v_nxt;
  logic signed [DRIVE_BITS-1:0] drive_r, drive_nxt;
  logic                         fire;
  logic signed [VW-1:0]         total;
  logic                         bump;
  logic signed [QW-1:0]         quot;

  assign up_ready     = !v_r || out_ch.ready;
  assign fire         = up_valid && up_ready;
  assign out_ch.valid = v_r;
  assign out_ch.drive = drive_r;

  always_comb begin
    total = (VW'(prod_p) <<< KP_SHIFT) + (VW'(prod_hi) <<< KI_SPLIT) + VW'(prod_lo);
    bump  = total[VW-1] && (|total[GAIN_FRAC_BITS-1:0]);
    quot  = total[VW-1:GAIN_FRAC_BITS] + $signed({{(QW-1){1'b0}}, bump});
    priority if (quot > QMAX) begin
      drive_nxt = DMAX;
    end else if (quot < QMIN) begin
      drive_nxt = DMIN;
    end else begin
      drive_nxt = quot[DRIVE_BITS-1:0];
    end
    v_nxt = fire || (v_r && !out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      drive_r <= drive_nxt;
    end
  end

endmodule

/* hw/rtl/ramped_setpoint_pi_servo_unit.sv */
`timescale 1ns / 1ps

// Ramped-setpoint PI position servo. Each input transaction is one control tick
// and yields exactly one drive transaction, in order. The unit sustains one
// transaction per clock while the sink takes results, passing each through
// three registered stages: the first updates the ramp point, tick counter, held
// error and saturating error sum, closing the tick-to-tick loop in that stage;
// the second forms the proportional and the two halves of the integral product;
// the third adds them, truncates toward zero and clamps to +/-100 into the output
// register. Ready drops only when all three stages hold results that the sink
// has not taken. Write configuration only while the unit is idle.
module ramped_setpoint_pi_servo_unit #(
  parameter int ANGLE_BITS = rsps_pkg::ANGLE_BITS_DEF,
  parameter int SUM_BITS   = rsps_pkg::SUM_BITS_DEF,
  parameter int CFG_BITS   = (ANGLE_BITS > rsps_pkg::CFG_MIN_BITS) ?
                             ANGLE_BITS : rsps_pkg::CFG_MIN_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  rsps_in_if.sink                             in_ch,
  rsps_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [rsps_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]                 cfg_wdata
);
  import rsps_pkg::*;

  localparam int PXW = ANGLE_BITS + KP_BITS + 3;
  localparam int PHW = SUM_BITS + KI_SPLIT + 1;

  ramp_cfg_t                   ramp_cfg_r;
  gain_cfg_t                   gain_cfg_r;
  logic signed [ANGLE_BITS-1:0] target_r;

  logic                         st_valid, st_ready;
  logic signed [ANGLE_BITS+1:0] held_error;
  logic signed [SUM_BITS-1:0]   error_sum;
  logic                         mu_valid, mu_ready;
  logic signed [PXW-1:0]        prod_p;
  logic signed [PHW-1:0]        prod_hi;
  logic signed [PHW-1:0]        prod_lo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_cfg_r.direction   <= 1'b1;
      ramp_cfg_r.count_limit <= '0;
      ramp_cfg_r.step_size   <= '0;
      target_r               <= '0;
      gain_cfg_r.kp_gain     <= KP_RESET;
      gain_cfg_r.ki_gain     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DIRECTION:    ramp_cfg_r.direction   <= cfg_wdata[0];
        REG_TARGET_ANGLE: target_r               <= cfg_wdata[ANGLE_BITS-1:0];
        REG_COUNT_LIMIT:  ramp_cfg_r.count_limit <= cfg_wdata[COUNT_BITS-1:0];
        REG_STEP_SIZE:    ramp_cfg_r.step_size   <= cfg_wdata[STEP_BITS-1:0];
        REG_KP_GAIN:      gain_cfg_r.kp_gain     <= cfg_wdata[KP_BITS-1:0];
        REG_KI_GAIN:      gain_cfg_r.ki_gain     <= cfg_wdata[KI_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  rsps_state #(
    .ANGLE_BITS (ANGLE_BITS),
    .SUM_BITS   (SUM_BITS)
  ) u_state (
    .clk            (clk),
    .rst_n          (rst_n),
    .up_valid       (in_ch.valid),
    .up_ready       (in_ch.ready),
    .measured_angle (in_ch.measured_angle),
    .restart        (in_ch.restart),
    .ramp_cfg       (ramp_cfg_r),
    .target_angle   (target_r),
    .dn_valid       (st_valid),
    .dn_ready       (st_ready),
    .held_error     (held_error),
    .error_sum      (error_sum)
  );

  rsps_mult #(
    .ANGLE_BITS (ANGLE_BITS),
    .SUM_BITS   (SUM_BITS)
  ) u_mult (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (st_valid),
    .up_ready   (st_ready),
    .held_error (held_error),
    .error_sum  (error_sum),
    .gain_cfg   (gain_cfg_r),
    .dn_valid   (mu_valid),
    .dn_ready   (mu_ready),
    .prod_p     (prod_p),
    .prod_hi    (prod_hi),
    .prod_lo    (prod_lo)
  );

  rsps_drive #(
    .ANGLE_BITS (ANGLE_BITS),
    .SUM_BITS   (SUM_BITS)
  ) u_drive (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (mu_valid),
    .up_ready (mu_ready),
    .prod_p   (prod_p),
    .prod_hi  (prod_hi),
    .prod_lo  (prod_lo),
    .out_ch   (out_ch)
  );

  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ((out_ch.drive <= 8'sd100) && (out_ch.drive >= -8'sd100)))
    else $error("drive outside clamp range");

  a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (st_valid && mu_valid && out_ch.valid))
    else $error("input stalled with a free stage");

  a_product_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (mu_valid && !mu_ready) |=> (mu_valid && $stable(prod_p) && $stable(prod_lo)))
    else $error("stalled product stage lost its transaction");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> (!out_ch.valid && !st_valid && !mu_valid))
    else $error("pipeline not empty after reset");

endmodule
